[rtl/ttl_dd_pkg.sv]
`timescale 1ns / 1ps

package ttl_dd_pkg;

	// Default table depth and the width of the index fields (up to 1024 entries).
	localparam int TABLE_ENTRIES_DEF = 32;
	localparam int TBL_IDX_W         = 10;

	// Time to live after reset, in milliseconds.
	localparam logic [31:0] WINDOW_RESET = 32'd30000;

	// Input action codes.
	localparam logic ACT_CHECK  = 1'b0;
	localparam logic ACT_RECORD = 1'b1;

	typedef logic [TBL_IDX_W-1:0] idx_t;

	// Controller sequence.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

	// Search token that walks down the row of cells, one cell per cycle.
	typedef struct packed {
		logic        step;
		logic        matched;
		logic        seen;
		logic        have_free;
		idx_t        match_idx;
		idx_t        free_idx;
		idx_t        victim_idx;
		logic [31:0] victim_age;
	} tok_t;

	// Values broadcast to every cell; hash and time are held steady while a transaction is scanned.
	typedef struct packed {
		logic [31:0] hash_value;
		logic [31:0] now_ms;
		logic [31:0] window_ms;
	} bcast_t;

	// Table write broadcast to all cells.
	typedef struct packed {
		logic        en;
		idx_t        idx;
		logic [31:0] hash_value;
		logic [31:0] stamp;
	} wr_t;

endpackage

[rtl/ttl_dd_ifs.sv]
`timescale 1ns / 1ps

// Input channel: one packet hash with its time and action.
interface ttl_dd_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] hash_value;
	logic [31:0] now_ms;

	modport source (output valid, output action, output hash_value, output now_ms,
		input ready);
	modport sink (input valid, input action, input hash_value, input now_ms,
		output ready);
endinterface

// Result channel: the seen flag.
interface ttl_dd_out_if;
	logic valid;
	logic ready;
	logic seen;

	modport source (output valid, output seen, input ready);
	modport sink (input valid, input seen, output ready);
endinterface

// Configuration channel: writes the time window.
interface ttl_dd_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] window_ms;

	modport source (output valid, output window_ms, input ready);
	modport sink (input valid, input window_ms, output ready);
endinterface

[rtl/ttl_dd_cell.sv]
`timescale 1ns / 1ps

module ttl_dd_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ttl_dd_pkg::bcast_t  bc,
	input  ttl_dd_pkg::wr_t     wr,
	input  ttl_dd_pkg::tok_t    tok_in,
	output ttl_dd_pkg::tok_t    tok_out
);
	import ttl_dd_pkg::*;

	localparam idx_t MY_IDX = TBL_IDX_W'(CELL_IDX);

	logic [31:0] hash_q;
	logic [31:0] stamp_q;
	logic        valid_q;
	tok_t        tok_q;
	tok_t        tok_nx;
	logic [31:0] age;
	logic        live;
	logic        hit;

	// Age of this entry and its standing against the current transaction.
	assign age  = bc.now_ms - stamp_q;
	assign live = valid_q && (age < bc.window_ms);
	assign hit  = valid_q && (hash_q == bc.hash_value);

	// Fold this entry into the search token.
	always_comb begin
		tok_nx = tok_in;
		tok_nx.seen = tok_in.seen | (hit & live);
		if (!tok_in.matched) begin
			if (hit) begin
				tok_nx.matched   = 1'b1;
				tok_nx.match_idx = MY_IDX;
			end else if (!live) begin
				if (!tok_in.have_free) begin
					tok_nx.have_free = 1'b1;
					tok_nx.free_idx  = MY_IDX;
				end
			end else if (age >= tok_in.victim_age) begin
				tok_nx.victim_age = age;
				tok_nx.victim_idx = MY_IDX;
			end
		end
	end

	// Token register toward the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nx;
		end
	end

	assign tok_out = tok_q;

	// Entry storage, written by the controller's broadcast.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr.en && (wr.idx == MY_IDX)) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && (wr.idx == MY_IDX)) begin
			hash_q  <= wr.hash_value;
			stamp_q <= wr.stamp;
		end
	end

endmodule

[rtl/ttl_dd_ctrl.sv]
`timescale 1ns / 1ps

module ttl_dd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	ttl_dd_in_if.sink          req,
	ttl_dd_out_if.source       rsp,
	ttl_dd_cfg_if.sink         cfg,
	output ttl_dd_pkg::bcast_t bc,
	output ttl_dd_pkg::wr_t    wr,
	output ttl_dd_pkg::tok_t   tok_first,
	input  ttl_dd_pkg::tok_t   tok_last
);
	import ttl_dd_pkg::*;

	state_t      state_q;
	state_t      state_nx;
	logic        action_q;
	logic [31:0] hash_q;
	logic [31:0] now_q;
	logic [31:0] window_q;
	logic        start_q;
	idx_t        slot_q;
	logic        seen_pend_q;
	logic        rsp_valid_q;
	logic        rsp_seen_q;
	logic        accept;
	logic        load_ok;
	logic        wr_en;

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:  if (req.valid) state_nx = ST_SCAN;
			ST_SCAN:  if (tok_last.step) state_nx = ST_WRITE;
			ST_WRITE: if (load_ok) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// Handshake and write strobes.
	always_comb begin
		req.ready = (state_q == ST_IDLE);
		load_ok   = !rsp_valid_q || rsp.ready;
		wr_en     = (state_q == ST_WRITE) && load_ok;
	end

	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			window_q    <= WINDOW_RESET;
		end else begin
			state_q <= state_nx;
			start_q <= accept;
			if (wr_en) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg.valid && cfg.ready) begin
				window_q <= cfg.window_ms;
			end
		end
	end

	// Transaction capture, slot decision at the end of the scan, result register.
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= req.action;
			hash_q   <= req.hash_value;
			now_q    <= req.now_ms;
		end
		if ((state_q == ST_SCAN) && tok_last.step) begin
			seen_pend_q <= (action_q == ACT_CHECK) && tok_last.seen;
			if (tok_last.matched) begin
				slot_q <= tok_last.match_idx;
			end else if (tok_last.have_free) begin
				slot_q <= tok_last.free_idx;
			end else begin
				slot_q <= tok_last.victim_idx;
			end
		end
		if (wr_en) begin
			rsp_seen_q <= seen_pend_q;
		end
	end

	// The first cell sees a fresh token with empty accumulators.
	always_comb begin
		tok_first      = '0;
		tok_first.step = start_q;
	end

	assign bc.hash_value = hash_q;
	assign bc.now_ms     = now_q;
	assign bc.window_ms  = window_q;

	assign wr.en         = wr_en;
	assign wr.idx        = slot_q;
	assign wr.hash_value = hash_q;
	assign wr.stamp      = now_q;

	assign rsp.valid = rsp_valid_q;
	assign rsp.seen  = rsp_seen_q;

endmodule

[rtl/ttl_dedup_table.sv]
// Each input transaction is scanned, decided and written back before the next one is taken.
// The search token walks the row of entry cells one cell per cycle, then the controller
// decides the slot and writes the entry back, waiting in the write state while an
// earlier result is still unread, and then returns to idle.
// A finished result waits in an output register while the next transaction is taken.
// Reset (arst_n, asynchronous, active low) clears all entry valid bits and sets the
// window to 30000 ms; no clearing pass is needed.
`timescale 1ns / 1ps

module ttl_dedup_table #(
	parameter int TABLE_ENTRIES = ttl_dd_pkg::TABLE_ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ttl_dd_in_if.sink     req,
	ttl_dd_out_if.source  rsp,
	ttl_dd_cfg_if.sink    cfg
);
	import ttl_dd_pkg::*;

	bcast_t bc;
	wr_t    wr;
	tok_t   tok [TABLE_ENTRIES+1];

	// Sequencing, window register and result register.
	ttl_dd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg       (cfg),
		.bc        (bc),
		.wr        (wr),
		.tok_first (tok[0]),
		.tok_last  (tok[TABLE_ENTRIES])
	);

	// Row of entry cells, each passing the search token to the next.
	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		ttl_dd_cell #(
			.CELL_IDX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.bc      (bc),
			.wr      (wr),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

endmodule
